@@ rtl/mrqm_pkg.sv @@
// ----------------------------------------------------------------------------
// Memory request queue package
// Shared constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package mrqm_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int ADDR_W    = 32;
    localparam int CYCLE_W   = 32;
    localparam int LATENCY_W = 16;
    localparam int SHIFT_W   = 5;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LATENCY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIPELINED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS = 2'd3;

    localparam logic [LATENCY_W-1:0] LATENCY_RESET   = 16'd10;
    localparam logic                 PIPELINED_RESET = 1'b1;
    localparam logic [SHIFT_W-1:0]   OFFSET_RESET    = 5'd6;

    typedef struct packed {
        logic load_in;
        logic scan_en;
        logic commit;
        logic head_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/mrqm_ctrl.sv @@
// ----------------------------------------------------------------------------
// Memory request queue controller
// Sequences one item through scan, commit, head read and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mrqm_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              req_valid,
    output logic             req_ready,
    input  mrqm_pkg::status_t status,
    output mrqm_pkg::cmd_t   cmd
);
    import mrqm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SCAN    = 5'b00010,
        ST_COMMIT  = 5'b00100,
        ST_HEAD_RD = 5'b01000,
        ST_RESULT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_HEAD_RD;
            end
            ST_HEAD_RD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ rtl/mrqm_dp.sv @@
// ----------------------------------------------------------------------------
// Memory request queue datapath
// Entry storage, queue pointers, duplicate scan, configuration and result.
// ----------------------------------------------------------------------------
`default_nettype none

module mrqm_dp #(
    parameter int DEPTH = mrqm_pkg::DEPTH_DEFAULT
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  mrqm_pkg::cmd_t                       cmd,
    output mrqm_pkg::status_t                    status,
    input  wire [mrqm_pkg::KIND_W-1:0]           kind,
    input  wire [mrqm_pkg::ADDR_W-1:0]           addr,
    input  wire                                  from_cpu,
    input  wire [mrqm_pkg::CYCLE_W-1:0]          cycle,
    input  wire                                  cfg_valid,
    input  wire [mrqm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [mrqm_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                 rsp_valid,
    input  wire                                  rsp_ready,
    output logic                                 ok,
    output logic                                 front_ready,
    output logic [mrqm_pkg::ADDR_W-1:0]          front_addr,
    output logic                                 front_from_cpu,
    output logic [$clog2(DEPTH+1)-1:0]           count
);
    import mrqm_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [LATENCY_W-1:0] latency_reg;
    logic                 pipelined_reg;
    logic [SHIFT_W-1:0]   offset_reg;

    logic [KIND_W-1:0]  kind_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               cpu_reg;
    logic [CYCLE_W-1:0] cycle_reg;

    logic [PW-1:0]      head_reg, head_next;
    logic [PW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      occ_reg, occ_next;
    logic [CYCLE_W-1:0] last_rt_reg, last_rt_next;
    logic               ok_reg, ok_next;

    logic [PW-1:0] scan_ptr_reg;
    logic [CW-1:0] issue_cnt_reg;
    logic [CW-1:0] scan_len_reg;
    logic          cmp_valid_reg;
    logic [PW-1:0] cmp_idx_reg;
    logic          found_reg;
    logic [PW-1:0] loc_reg;
    logic          loc_demand_reg;

    logic [ADDR_W-1:0]  mem_addr   [DEPTH];
    logic               mem_demand [DEPTH];
    logic [CYCLE_W-1:0] mem_rt     [DEPTH];
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic               rd_demand_reg;
    logic [CYCLE_W-1:0] rd_rt_reg;

    logic               issue;
    logic               rd_en;
    logic [PW-1:0]      rd_idx;
    logic               match;
    logic               full;
    logic               wr_en;
    logic               wr_rt_en;
    logic [PW-1:0]      wr_idx;
    logic               wr_demand;
    logic [CYCLE_W-1:0] new_rt;

    logic               rsp_valid_reg;
    logic               ok_out_reg;
    logic               front_ready_reg;
    logic [ADDR_W-1:0]  front_addr_reg;
    logic               front_cpu_reg;
    logic [CW-1:0]      count_reg;

    // The set index width is held by software only: matching uses the whole
    // block number, which is tag and set index together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latency_reg   <= LATENCY_RESET;
            pipelined_reg <= PIPELINED_RESET;
            offset_reg    <= OFFSET_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LATENCY:    latency_reg   <= cfg_data;
                CFG_PIPELINED:  pipelined_reg <= cfg_data[0];
                CFG_OFFSET:     offset_reg    <= cfg_data[SHIFT_W-1:0];
                CFG_INDEX_BITS: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg  <= kind;
            addr_reg  <= addr;
            cpu_reg   <= from_cpu;
            cycle_reg <= cycle;
        end
    end

    assign full  = (occ_reg == CW'(DEPTH));
    assign issue = cmd.scan_en && (issue_cnt_reg != scan_len_reg);
    assign rd_en = issue || cmd.head_rd;
    assign rd_idx = cmd.head_rd ? head_reg : scan_ptr_reg;
    assign match = cmp_valid_reg && (((rd_addr_reg ^ addr_reg) >> offset_reg) == '0);

    assign status.scan_done = (issue_cnt_reg == scan_len_reg) && !cmp_valid_reg;
    assign status.out_free  = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            scan_len_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else if (cmd.load_in)
        begin
            issue_cnt_reg <= '0;
            scan_len_reg  <= (kind == KIND_ADD && !full) ? occ_reg : '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
            cmp_valid_reg <= issue;
            if (match)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            scan_ptr_reg <= head_reg;
        end
        else if (issue)
        begin
            scan_ptr_reg <= ptr_inc(scan_ptr_reg);
        end
        if (issue)
        begin
            cmp_idx_reg <= scan_ptr_reg;
        end
        if (match)
        begin
            loc_reg        <= cmp_idx_reg;
            loc_demand_reg <= rd_demand_reg;
        end
    end

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        last_rt_next = last_rt_reg;
        ok_next      = ok_reg;
        wr_en        = 1'b0;
        wr_rt_en     = 1'b0;
        wr_idx       = tail_reg;
        wr_demand    = cpu_reg;
        new_rt       = (pipelined_reg || occ_reg == '0) ?
                       cycle_reg + CYCLE_W'(latency_reg) :
                       last_rt_reg + CYCLE_W'(latency_reg);
        if (cmd.commit)
        begin
            ok_next = 1'b0;
            case (kind_reg)
                KIND_ADD:
                begin
                    if (!full)
                    begin
                        ok_next = 1'b1;
                        if (!found_reg || loc_demand_reg)
                        begin
                            wr_en        = 1'b1;
                            wr_rt_en     = 1'b1;
                            tail_next    = ptr_inc(tail_reg);
                            occ_next     = occ_reg + 1'b1;
                            last_rt_next = new_rt;
                        end
                        else if (cpu_reg)
                        begin
                            wr_en     = 1'b1;
                            wr_idx    = loc_reg;
                            wr_demand = 1'b1;
                        end
                    end
                end
                KIND_REMOVE:
                begin
                    if (occ_reg != '0)
                    begin
                        ok_next   = 1'b1;
                        head_next = ptr_inc(head_reg);
                        occ_next  = occ_reg - 1'b1;
                    end
                end
                KIND_PEEK:
                begin
                    ok_next = (occ_reg != '0);
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
            ok_reg   <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
            ok_reg   <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_rt_reg <= last_rt_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_addr[wr_idx]   <= addr_reg;
            mem_demand[wr_idx] <= wr_demand;
        end
        if (wr_rt_en)
        begin
            mem_rt[wr_idx] <= new_rt;
        end
        if (rd_en)
        begin
            rd_addr_reg   <= mem_addr[rd_idx];
            rd_demand_reg <= mem_demand[rd_idx];
            rd_rt_reg     <= mem_rt[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ok_out_reg      <= ok_reg;
            front_ready_reg <= (occ_reg != '0) && (rd_rt_reg <= cycle_reg);
            front_addr_reg  <= (occ_reg != '0) ? rd_addr_reg : '0;
            front_cpu_reg   <= (occ_reg != '0) && rd_demand_reg;
            count_reg       <= occ_reg;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign ok             = ok_out_reg;
    assign front_ready    = front_ready_reg;
    assign front_addr     = front_addr_reg;
    assign front_from_cpu = front_cpu_reg;
    assign count          = count_reg;

endmodule

`default_nettype wire

@@ rtl/memory_request_queue_merge.sv @@
// ----------------------------------------------------------------------------
// Memory request queue with duplicate merge
// Circular queue of memory requests that merges duplicate block requests.
// ----------------------------------------------------------------------------
// Items arrive on the req channel (kind, addr, from_cpu, cycle) and each one
// produces exactly one result item on the rsp channel (ok, front_ready,
// front_addr, front_from_cpu, count). Configuration registers are written on
// the cfg channel, which is always ready; write only while the block is idle.
// The block works on one item at a time. An add scans the live entries
// through a single memory read port, one entry per cycle. Remove, peek and
// an add to an empty or full queue skip the scan. The next item can be
// accepted in the cycle after its predecessor's result is loaded into the
// output register. While the receiver stalls, the result stays in the output
// register and the next item is processed up to its own hand-off. Reset
// empties the queue and restores the register defaults; entry storage is
// not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_request_queue_merge #(
    parameter int DEPTH = mrqm_pkg::DEPTH_DEFAULT
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  req_valid,
    output logic                                 req_ready,
    input  wire [mrqm_pkg::KIND_W-1:0]           kind,
    input  wire [mrqm_pkg::ADDR_W-1:0]           addr,
    input  wire                                  from_cpu,
    input  wire [mrqm_pkg::CYCLE_W-1:0]          cycle,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [mrqm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [mrqm_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                 rsp_valid,
    input  wire                                  rsp_ready,
    output logic                                 ok,
    output logic                                 front_ready,
    output logic [mrqm_pkg::ADDR_W-1:0]          front_addr,
    output logic                                 front_from_cpu,
    output logic [$clog2(DEPTH+1)-1:0]           count
);
    import mrqm_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    mrqm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mrqm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .kind           (kind),
        .addr           (addr),
        .from_cpu       (from_cpu),
        .cycle          (cycle),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .ok             (ok),
        .front_ready    (front_ready),
        .front_addr     (front_addr),
        .front_from_cpu (front_from_cpu),
        .count          (count)
    );

endmodule

`default_nettype wire

@@ rtl/mrqm_checker.sv @@
// ----------------------------------------------------------------------------
// Memory request queue port checker
// Checks result consistency and handshake behavior seen at the ports.
// ----------------------------------------------------------------------------
`default_nettype none

module mrqm_checker #(
    parameter int DEPTH = mrqm_pkg::DEPTH_DEFAULT
) (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          req_valid,
    input wire                          req_ready,
    input wire                          rsp_valid,
    input wire                          rsp_ready,
    input wire                          ok,
    input wire                          front_ready,
    input wire [mrqm_pkg::ADDR_W-1:0]   front_addr,
    input wire                          front_from_cpu,
    input wire [$clog2(DEPTH+1)-1:0]    count
);
    import mrqm_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(ok) && $stable(front_ready)
            && $stable(front_addr) && $stable(front_from_cpu) && $stable(count))
        else $error("Result item changed while stalled.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> count <= ($clog2(DEPTH+1))'(DEPTH))
        else $error("Reported count exceeds the queue depth.");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && count == '0 |-> !front_ready && front_addr == '0 && !front_from_cpu)
        else $error("Empty queue reports a head entry.");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("Next item accepted before the current one finished.");

endmodule

bind memory_request_queue_merge mrqm_checker #(
    .DEPTH (DEPTH)
) u_mrqm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .ok             (ok),
    .front_ready    (front_ready),
    .front_addr     (front_addr),
    .front_from_cpu (front_from_cpu),
    .count          (count)
);

`default_nettype wire

@@ tb/tb_memory_request_queue_merge.sv @@
// ----------------------------------------------------------------------------
// Memory request queue with duplicate merge testbench
// Drives add, remove, peek and undefined items through the request channel,
// rewrites the four configuration registers between phases while the queue
// is idle, and checks every result against a scoreboard that keeps its own
// copy of the queue contents, ready times and register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class request_queue_scoreboard;

    localparam int SLOTS = mrqm_pkg::DEPTH_DEFAULT;

    typedef struct {
        logic        ok;
        logic        front_ready;
        logic [31:0] front_addr;
        logic        front_from_cpu;
        logic [4:0]  count;
    } queue_status_t;

    logic [31:0]   slot_addr[SLOTS];
    logic          slot_cpu[SLOTS];
    logic [31:0]   slot_due[SLOTS];
    int unsigned   head;
    int unsigned   tail;
    int unsigned   fill;

    logic [15:0]   latency_r;
    logic          pipelined_r;
    logic [4:0]    offset_r;
    logic [4:0]    index_bits_r;

    queue_status_t status_fifo[$];
    int unsigned   mismatches;

    function new();
        head         = 0;
        tail         = 0;
        fill         = 0;
        latency_r    = mrqm_pkg::LATENCY_RESET;
        pipelined_r  = mrqm_pkg::PIPELINED_RESET;
        offset_r     = mrqm_pkg::OFFSET_RESET;
        index_bits_r = 5'd8;
        mismatches   = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
        case (idx)
            mrqm_pkg::CFG_LATENCY:    latency_r    = data;
            mrqm_pkg::CFG_PIPELINED:  pipelined_r  = data[0];
            mrqm_pkg::CFG_OFFSET:     offset_r     = data[4:0];
            mrqm_pkg::CFG_INDEX_BITS: index_bits_r = data[4:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return status_fifo.size();
    endfunction

    function void note_request(logic [1:0] op, logic [31:0] a, logic cpu, logic [31:0] cyc);
        queue_status_t st;
        logic          hit;
        int unsigned   loc;
        int unsigned   p;
        logic [31:0]   due;

        st  = '{default: '0};
        hit = 1'b0;
        loc = 0;
        if (op == mrqm_pkg::KIND_ADD) begin
            if (fill < SLOTS) begin
                st.ok = 1'b1;
                p = head;
                for (int n = 0; n < fill; n++)
                begin
                    if ((slot_addr[p] >> offset_r) == (a >> offset_r))
                    begin
                        hit = 1'b1;
                        loc = p;
                    end
                    p = (p + 1) % SLOTS;
                end
                if (!hit || slot_cpu[loc]) begin
                    if (pipelined_r || fill == 0)
                        due = cyc + latency_r;
                    else
                        due = slot_due[(tail + SLOTS - 1) % SLOTS] + latency_r;
                    slot_addr[tail] = a;
                    slot_cpu[tail]  = cpu;
                    slot_due[tail]  = due;
                    fill++;
                    tail = (tail + 1) % SLOTS;
                end
                else if (cpu) begin
                    slot_addr[loc] = a;
                    slot_cpu[loc]  = 1'b1;
                end
            end
        end
        else if (op == mrqm_pkg::KIND_REMOVE) begin
            if (fill > 0) begin
                fill--;
                head  = (head + 1) % SLOTS;
                st.ok = 1'b1;
            end
        end
        else if (op == mrqm_pkg::KIND_PEEK) begin
            st.ok = (fill > 0);
        end

        if (fill > 0) begin
            st.front_ready    = (slot_due[head] <= cyc);
            st.front_addr     = slot_addr[head];
            st.front_from_cpu = slot_cpu[head];
        end
        st.count = fill[4:0];
        status_fifo.push_back(st);
    endfunction

    function void compare_field(string name, logic [31:0] expv, logic [31:0] actv);
        if (actv !== expv) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expv, actv);
            mismatches++;
        end
    endfunction

    function void check_response(logic ok_v, logic fr_v, logic [31:0] fa_v, logic fc_v,
                                 logic [4:0] cnt_v);
        queue_status_t st;

        if (status_fifo.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual ok=%b count=%0d",
                     $time, ok_v, cnt_v);
            mismatches++;
            return;
        end
        st = status_fifo.pop_front();
        compare_field("ok", 32'(st.ok), 32'(ok_v));
        compare_field("front_ready", 32'(st.front_ready), 32'(fr_v));
        compare_field("front_addr", st.front_addr, fa_v);
        compare_field("front_from_cpu", 32'(st.front_from_cpu), 32'(fc_v));
        compare_field("count", 32'(st.count), 32'(cnt_v));
    endfunction

endclass

module tb_memory_request_queue_merge;

    localparam logic [1:0] KIND_UNDEFINED = 2'd3;
    localparam int         CYCLE_LIMIT    = 1000000;
    localparam int         ITEMS_PER_PHASE = 235;
    localparam int         POOL_SIZE      = 6;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [1:0]  kind;
    logic [31:0] addr;
    logic        from_cpu;
    logic [31:0] cycle;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        rsp_valid;
    logic        rsp_ready;
    logic        ok;
    logic        front_ready;
    logic [31:0] front_addr;
    logic        front_from_cpu;
    logic [4:0]  count;

    request_queue_scoreboard sb;
    int          idle_pct;
    int unsigned tick_count;
    logic [31:0] sim_cycle;
    logic [4:0]  cur_offset;
    logic [31:0] block_pool[POOL_SIZE];

    memory_request_queue_merge i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .kind           (kind),
        .addr           (addr),
        .from_cpu       (from_cpu),
        .cycle          (cycle),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .ok             (ok),
        .front_ready    (front_ready),
        .front_addr     (front_addr),
        .front_from_cpu (front_from_cpu),
        .count          (count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        tick_count <= tick_count + 1;
        if (tick_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            sb.check_response(ok, front_ready, front_addr, front_from_cpu, count);
        rsp_ready <= (idle_pct == 0) || ($urandom_range(0, 99) >= idle_pct);
    end

    task automatic send_request(input logic [1:0] op, input logic [31:0] a,
                                input logic cpu, input logic [31:0] cyc);
        int gap;

        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        kind      <= op;
        addr      <= a;
        from_cpu  <= cpu;
        cycle     <= cyc;
        @(posedge clk);
        while (req_ready !== 1'b1) @(posedge clk);
        sb.note_request(op, a, cpu, cyc);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] lat, input logic pipe,
                                  input logic [4:0] off, input logic [4:0] idx_bits);
        logic [15:0] noise;

        noise = $urandom_range(0, 1) ? 16'($urandom) : 16'h0000;
        write_reg(mrqm_pkg::CFG_LATENCY, lat);
        write_reg(mrqm_pkg::CFG_PIPELINED, {noise[15:1], pipe});
        write_reg(mrqm_pkg::CFG_OFFSET, {noise[15:5], off});
        write_reg(mrqm_pkg::CFG_INDEX_BITS, {noise[10:0], idx_bits});
        cfg_valid  <= 1'b0;
        cur_offset = off;
        for (int i = 0; i < POOL_SIZE; i++)
            block_pool[i] = $urandom;
    endtask

    task automatic run_directed();
        send_request(mrqm_pkg::KIND_PEEK, 32'h0000_0000, 1'b0, 32'd0);
        send_request(mrqm_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_request(KIND_UNDEFINED, 32'hFFFF_FFFF, 1'b1, 32'd0);
        send_request(mrqm_pkg::KIND_ADD, 32'h0000_0000, 1'b1, 32'd0);
        send_request(mrqm_pkg::KIND_PEEK, 32'h0000_0000, 1'b0, 32'd10);
        // A prefetch whose ready time wraps past the top of the cycle range.
        send_request(mrqm_pkg::KIND_ADD, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFF8);
        send_request(mrqm_pkg::KIND_ADD, 32'hFFFF_FFC0, 1'b0, 32'hFFFF_FFF9);
        send_request(mrqm_pkg::KIND_ADD, 32'hFFFF_FFC5, 1'b1, 32'hFFFF_FFFA);
        send_request(mrqm_pkg::KIND_ADD, 32'hFFFF_FFD0, 1'b1, 32'hFFFF_FFFB);
        send_request(KIND_UNDEFINED, 32'h0000_0000, 1'b0, 32'hFFFF_FFFC);
        send_request(mrqm_pkg::KIND_REMOVE, 32'h0000_0000, 1'b0, 32'd1);
        send_request(mrqm_pkg::KIND_PEEK, 32'h0000_0000, 1'b0, 32'd2);
        for (int i = 1; i <= 14; i++)
            send_request(mrqm_pkg::KIND_ADD, 32'(i) << 6, i[0], 32'(i + 2));
        send_request(mrqm_pkg::KIND_ADD, 32'h1234_5678, 1'b1, 32'd20);
    endtask

    task automatic run_random(input int n, input int add_pct);
        int          r;
        logic [1:0]  op;
        logic [31:0] a;
        logic [31:0] low_mask;

        low_mask = ~(32'hFFFF_FFFF << cur_offset);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < add_pct)
                op = mrqm_pkg::KIND_ADD;
            else if ($urandom_range(0, 99) < 65)
                op = mrqm_pkg::KIND_REMOVE;
            else if ($urandom_range(0, 99) < 80)
                op = mrqm_pkg::KIND_PEEK;
            else
                op = KIND_UNDEFINED;
            if ($urandom_range(0, 9) < 8)
                a = block_pool[$urandom_range(0, POOL_SIZE - 1)] ^ ($urandom & low_mask);
            else
                a = $urandom;
            if ($urandom_range(0, 99) < 5)
                sim_cycle = $urandom;
            else
                sim_cycle = sim_cycle + $urandom_range(0, 12);
            send_request(op, a, 1'($urandom_range(0, 1)), sim_cycle);
        end
    endtask

    initial
    begin
        sb         = new();
        clk        = 1'b0;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        kind       = mrqm_pkg::KIND_PEEK;
        addr       = '0;
        from_cpu   = 1'b0;
        cycle      = '0;
        cfg_valid  = 1'b0;
        cfg_index  = mrqm_pkg::CFG_LATENCY;
        cfg_data   = '0;
        rsp_ready  = 1'b0;
        idle_pct   = 15;
        tick_count = 0;
        sim_cycle  = '0;
        cur_offset = mrqm_pkg::OFFSET_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            idle_pct = (ph == 2) ? 0 : 15;
            case (ph)
                0: apply_settings(16'd0, 1'b1, 5'd0, 5'd0);
                1: apply_settings(16'hFFFF, 1'b0, 5'd31, 5'd26);
                2: apply_settings(16'd7, 1'b0, 5'd6, 5'd8);
                3: apply_settings(16'd25, 1'b1, 5'd12, 5'd31);
                4: apply_settings(16'd3, 1'b0, 5'd1, 5'd5);
                5: apply_settings(16'd40000, 1'b1, 5'd20, 5'd0);
                6: apply_settings(16'($urandom_range(0, 60)), 1'($urandom_range(0, 1)),
                                  5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
                default: apply_settings(16'd12, 1'b0, 5'd4, 5'd16);
            endcase
            case (ph % 3)
                0: run_random(ITEMS_PER_PHASE, 55);
                1: run_random(ITEMS_PER_PHASE, 62);
                default: run_random(ITEMS_PER_PHASE, 40);
            endcase
            wait_drained();
        end

        repeat (30) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mrqm_pkg.sv
rtl/mrqm_ctrl.sv
rtl/mrqm_dp.sv
rtl/memory_request_queue_merge.sv
rtl/mrqm_checker.sv
tb/tb_memory_request_queue_merge.sv
